// ===== hdl/fstc_pkg.sv =====
// ----------------------------------------------------------------------------
// fstc_pkg
// Shared constants, status codes and divider request types for the Fst estimator.
// ----------------------------------------------------------------------------
package fstc_pkg;

	// Default sizes of the count table.
	localparam int DEF_MAX_POPULATIONS = 16;
	localparam int DEF_MAX_ALLELES     = 64;
	localparam int DEF_COUNT_BITS      = 16;

	// Width of a population total.
	localparam int TOTAL_BITS = 22;

	// Width of one Q32 proportion, which may reach exactly one.
	localparam int Q_W = 33;

	// Divider sizes: a sum of count products shifted up by 32 fraction bits.
	localparam int DEN_W  = 2 * TOTAL_BITS;
	localparam int DIVD_W = DEN_W + 32;

	// One in Q32.
	localparam logic [Q_W-1:0] ONE_Q32 = {1'b1, 32'h0000_0000};

	// Status codes of a result.
	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_ALLELE   = 3'd1,
		STAT_POPS     = 3'd2,
		STAT_MB_ONE   = 3'd3,
		STAT_ZERO_DIV = 3'd4,
		STAT_SAT      = 3'd5
	} fst_status_t;

	// Request to the shared divider.
	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DEN_W-1:0]  divisor;
	} div_req_t;

	// Answer of the shared divider.
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/fstc_ram.sv =====
// ----------------------------------------------------------------------------
// fstc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module fstc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; a read of the address being written returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/fstc_div.sv =====
// ----------------------------------------------------------------------------
// fstc_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module fstc_div import fstc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] dvd_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	// One step: bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q, dvd_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			dvd_q <= {dvd_q[DIVD_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ===== hdl/fst_from_allele_count_table.sv =====
// ----------------------------------------------------------------------------
// fst_from_allele_count_table
// Fst estimate from a stream of (population, allele) samples.
// ----------------------------------------------------------------------------
// Samples arrive one per cycle and increment a count table held in RAM; a
// sample that follows one to the same cell is forwarded around the RAM, so
// the stream never stalls during counting. The sample marked tlast starts the
// final pass, which walks every pair of non-empty populations (a population
// paired with itself gives its homozygosity) over all alleles, one allele per
// cycle, and runs one bit-serial division for each pair, one for the mean
// sharing and one for the result. After reset and after every result a
// clearing pass writes all MAX_POPULATIONS * MAX_ALLELES cells of the count
// table (1024 by default) to zero, during which no sample is taken. The
// result waits in an output register, so the clearing pass and the next set
// go on while it is not yet taken.
// ----------------------------------------------------------------------------
module fst_from_allele_count_table import fstc_pkg::*; #(
	parameter int MAX_POPULATIONS = DEF_MAX_POPULATIONS,
	parameter int MAX_ALLELES     = DEF_MAX_ALLELES,
	parameter int COUNT_BITS      = DEF_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: frequency_mode.
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	// Sample requests.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [3:0] pop_index, [9:4] allele_index, rest zero
	input  logic        s_axis_tlast,   // last
	// Result requests.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] fst_value
	output logic [2:0]  m_axis_tuser    // [2:0] status
);

	localparam int DEPTH  = MAX_POPULATIONS * MAX_ALLELES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int POP_W  = $clog2(MAX_POPULATIONS);
	localparam int AL_W   = $clog2(MAX_ALLELES);
	localparam int NP_W   = $clog2(MAX_POPULATIONS + 1);
	localparam int ACC_W  = 2 * TOTAL_BITS;
	localparam int SUM_W  = Q_W + NP_W;
	localparam int PSUM_W = Q_W + 2 * NP_W;
	localparam int PROD_W = 2 * COUNT_BITS;

	localparam logic [DIVD_W-1:0] FST_ONE = DIVD_W'(64'h8000_0000);

	typedef enum logic [16:0] {
		ST_CLEAR    = 17'h00001,
		ST_ACCUM    = 17'h00002,
		ST_CHECK    = 17'h00004,
		ST_P_SEL    = 17'h00008,
		ST_Q_SEL    = 17'h00010,
		ST_RUN      = 17'h00020,
		ST_DRAIN    = 17'h00040,
		ST_DIV_GO   = 17'h00080,
		ST_DIV_WAIT = 17'h00100,
		ST_NEXT_Q   = 17'h00200,
		ST_NEXT_P   = 17'h00400,
		ST_MB_GO    = 17'h00800,
		ST_MB_WAIT  = 17'h01000,
		ST_MB_CHK   = 17'h02000,
		ST_FST_GO   = 17'h04000,
		ST_FST_WAIT = 17'h08000,
		ST_EMIT     = 17'h10000
	} state_t;

	state_t state_q;

	// Configuration and bookkeeping of the current set.
	logic                  mode_q;
	logic [TOTAL_BITS-1:0] totals_q [MAX_POPULATIONS];
	logic [NP_W-1:0]       npop_q;
	logic                  sat_q;
	logic                  first_v_q;
	logic [AL_W-1:0]       first_al_q;
	logic                  multi_q;

	// Counting pipeline.
	logic                  v_s1;
	logic                  inr_s1;
	logic                  last_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [POP_W-1:0]      pop_s1;
	logic [AL_W-1:0]       al_s1;
	logic                  fwd_v_q;
	logic [ADDR_W-1:0]     fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	// Final pass.
	logic [ADDR_W-1:0]     clr_addr_q;
	logic [POP_W-1:0]      p_q;
	logic [POP_W-1:0]      q_q;
	logic [AL_W-1:0]       a_q;
	logic [TOTAL_BITS-1:0] tp_q;
	logic [TOTAL_BITS-1:0] tq_q;
	logic                  rv_s1;
	logic                  pv_s2;
	logic [PROD_W-1:0]     prod_s2;
	logic [ACC_W-1:0]      acc_q;
	logic [DEN_W-1:0]      den_q;
	logic                  zero_div_q;
	logic [SUM_W-1:0]      sum_mi_q;
	logic [PSUM_W-1:0]     pairsum_q;
	logic [Q_W-1:0]        mb_q;
	logic [SUM_W-1:0]      sub_q;
	logic [SUM_W-1:0]      fden_q;
	logic [31:0]           res_fst_q;
	logic [2:0]            res_status_q;

	// Output register.
	logic                  out_valid_q;
	logic [31:0]           out_fst_q;
	logic [2:0]            out_status_q;

	// Combinational signals.
	logic [3:0]            in_pop;
	logic [5:0]            in_al;
	logic                  in_acc;
	logic                  in_range;
	logic [ADDR_W-1:0]     in_addr;
	logic [ADDR_W-1:0]     rd_addr_a;
	logic [ADDR_W-1:0]     rd_addr_b;
	logic [COUNT_BITS-1:0] rdata_a;
	logic [COUNT_BITS-1:0] rdata_b;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic [TOTAL_BITS-1:0] tot_rd;
	logic [POP_W-1:0]      tot_idx;
	logic                  do_cnt;
	logic                  cnt_we;
	logic                  diag;
	logic [COUNT_BITS-1:0] opb;
	logic [TOTAL_BITS-1:0] opd;
	logic [2*NP_W-1:0]     pair_prod;
	logic [2*NP_W-1:0]     pairs;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	// Input fields and table address of the offered sample.
	assign in_pop   = s_axis_tdata[3:0];
	assign in_al    = s_axis_tdata[9:4];
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign in_range = (32'(in_pop) < MAX_POPULATIONS) && (32'(in_al) < MAX_ALLELES);
	assign in_addr  = ADDR_W'(32'(in_pop) * MAX_ALLELES + 32'(in_al));

	// Samples are taken while counting, up to the sample that closes the set.
	assign s_axis_tready = (state_q == ST_ACCUM) && !(v_s1 && last_s1);

	// Two identical copies of the count table give two read ports.
	assign rd_addr_a = (state_q == ST_RUN) ? ADDR_W'(32'(p_q) * MAX_ALLELES + 32'(a_q))
	                                       : in_addr;
	assign rd_addr_b = ADDR_W'(32'(q_q) * MAX_ALLELES + 32'(a_q));

	fstc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr_a),
		.rdata (rdata_a)
	);

	fstc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr_b),
		.rdata (rdata_b)
	);

	// Read-modify-write of one count, with the previous write forwarded.
	assign cur_cnt = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata_a;
	assign tot_idx = (state_q == ST_P_SEL) ? p_q : ((state_q == ST_Q_SEL) ? q_q : pop_s1);
	assign tot_rd = totals_q[tot_idx];
	assign do_cnt = (state_q == ST_ACCUM) && v_s1 && inr_s1;
	assign cnt_we = do_cnt && !(&cur_cnt) && !(&tot_rd);

	assign ram_we    = (state_q == ST_CLEAR) || cnt_we;
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : addr_s1;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : cur_cnt + COUNT_BITS'(1);

	// Product operands: in pairwise mode a population against itself uses n(n-1).
	assign diag = (p_q == q_q);
	always_comb begin
		opb = rdata_b;
		if (diag && !mode_q && rdata_b != '0) begin
			opb = rdata_b - COUNT_BITS'(1);
		end
		opd = tq_q;
		if (diag) begin
			opd = mode_q ? tp_q : tp_q - TOTAL_BITS'(1);
		end
	end

	// Number of population pairs for the mean sharing.
	assign pair_prod = (2*NP_W)'(npop_q) * (2*NP_W)'(npop_q - NP_W'(1));
	assign pairs     = pair_prod >> 1;

	// Requests to the shared divider.
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_DIV_GO: begin
				div_req.start    = (den_q != '0);
				div_req.dividend = DIVD_W'(acc_q) << 32;
				div_req.divisor  = den_q;
			end
			ST_MB_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIVD_W'(pairsum_q);
				div_req.divisor  = DEN_W'(pairs);
			end
			ST_FST_GO: begin
				div_req.start    = (sum_mi_q > sub_q);
				div_req.dividend = DIVD_W'(sum_mi_q - sub_q) << 31;
				div_req.divisor  = DEN_W'(fden_q);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	fstc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Counting pipeline and product pipeline data.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1 <= in_addr;
			pop_s1  <= POP_W'(in_pop);
			al_s1   <= AL_W'(in_al);
			inr_s1  <= in_range;
			last_s1 <= s_axis_tlast;
		end
		fwd_addr_q <= addr_s1;
		fwd_data_q <= ram_wdata;
		prod_s2    <= {COUNT_BITS'(0), rdata_a} * {COUNT_BITS'(0), opb};
		den_q      <= {TOTAL_BITS'(0), tp_q} * {TOTAL_BITS'(0), opd};
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			mode_q       <= 1'b1;
			for (int i = 0; i < MAX_POPULATIONS; i++) begin
				totals_q[i] <= '0;
			end
			npop_q       <= '0;
			sat_q        <= 1'b0;
			first_v_q    <= 1'b0;
			first_al_q   <= '0;
			multi_q      <= 1'b0;
			v_s1         <= 1'b0;
			fwd_v_q      <= 1'b0;
			clr_addr_q   <= '0;
			p_q          <= '0;
			q_q          <= '0;
			a_q          <= '0;
			tp_q         <= '0;
			tq_q         <= '0;
			rv_s1        <= 1'b0;
			pv_s2        <= 1'b0;
			acc_q        <= '0;
			zero_div_q   <= 1'b0;
			sum_mi_q     <= '0;
			pairsum_q    <= '0;
			mb_q         <= '0;
			sub_q        <= '0;
			fden_q       <= '0;
			res_fst_q    <= '0;
			res_status_q <= STAT_OK;
			out_valid_q  <= 1'b0;
			out_fst_q    <= '0;
			out_status_q <= STAT_OK;
		end else begin
			if (cfg_wen) begin
				mode_q <= cfg_wdata;
			end

			// Output register hands over its result.
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			v_s1    <= in_acc;
			fwd_v_q <= cnt_we;

			// Count one sample, or note that its count or total is full.
			if (do_cnt) begin
				if (!cnt_we) begin
					sat_q <= 1'b1;
				end else begin
					totals_q[pop_s1] <= tot_rd + TOTAL_BITS'(1);
					if (tot_rd == '0) begin
						npop_q <= npop_q + NP_W'(1);
					end
					if (!first_v_q) begin
						first_v_q  <= 1'b1;
						first_al_q <= al_s1;
					end else if (al_s1 != first_al_q) begin
						multi_q <= 1'b1;
					end
				end
			end

			// Product pipeline for the allele walk.
			rv_s1 <= (state_q == ST_RUN);
			pv_s2 <= rv_s1;
			if (pv_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end

			case (state_q)
				ST_CLEAR: begin
					if (32'(clr_addr_q) == DEPTH - 1) begin
						clr_addr_q <= '0;
						state_q    <= ST_ACCUM;
					end else begin
						clr_addr_q <= clr_addr_q + ADDR_W'(1);
					end
				end
				ST_ACCUM: begin
					if (v_s1 && last_s1) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					res_fst_q  <= '0;
					zero_div_q <= 1'b0;
					sum_mi_q   <= '0;
					pairsum_q  <= '0;
					p_q        <= '0;
					if (sat_q) begin
						res_status_q <= STAT_SAT;
						state_q      <= ST_EMIT;
					end else if (!multi_q) begin
						res_status_q <= STAT_ALLELE;
						state_q      <= ST_EMIT;
					end else if (npop_q < NP_W'(2)) begin
						res_status_q <= STAT_POPS;
						state_q      <= ST_EMIT;
					end else begin
						res_status_q <= STAT_OK;
						state_q      <= ST_P_SEL;
					end
				end
				ST_P_SEL: begin
					tp_q <= tot_rd;
					q_q  <= p_q;
					state_q <= (tot_rd == '0) ? ST_NEXT_P : ST_Q_SEL;
				end
				ST_Q_SEL: begin
					tq_q  <= tot_rd;
					acc_q <= '0;
					a_q   <= '0;
					state_q <= (tot_rd == '0) ? ST_NEXT_Q : ST_RUN;
				end
				ST_RUN: begin
					a_q <= a_q + AL_W'(1);
					if (32'(a_q) == MAX_ALLELES - 1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rv_s1 && !pv_s2) begin
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: begin
					if (den_q == '0) begin
						zero_div_q <= 1'b1;
						state_q    <= ST_NEXT_Q;
					end else begin
						state_q <= ST_DIV_WAIT;
					end
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (diag) begin
							sum_mi_q <= sum_mi_q + SUM_W'(div_rsp.quotient[Q_W-1:0]);
						end else begin
							pairsum_q <= pairsum_q + PSUM_W'(div_rsp.quotient[Q_W-1:0]);
						end
						state_q <= ST_NEXT_Q;
					end
				end
				ST_NEXT_Q: begin
					if (32'(q_q) == MAX_POPULATIONS - 1) begin
						state_q <= ST_NEXT_P;
					end else begin
						q_q     <= q_q + POP_W'(1);
						state_q <= ST_Q_SEL;
					end
				end
				ST_NEXT_P: begin
					if (32'(p_q) == MAX_POPULATIONS - 1) begin
						state_q <= ST_MB_GO;
					end else begin
						p_q     <= p_q + POP_W'(1);
						state_q <= ST_P_SEL;
					end
				end
				ST_MB_GO: begin
					state_q <= ST_MB_WAIT;
				end
				ST_MB_WAIT: begin
					if (div_rsp.done) begin
						mb_q    <= div_rsp.quotient[Q_W-1:0];
						state_q <= ST_MB_CHK;
					end
				end
				ST_MB_CHK: begin
					sub_q  <= SUM_W'(npop_q) * SUM_W'(mb_q);
					fden_q <= SUM_W'(npop_q) * SUM_W'(ONE_Q32 - mb_q);
					if (mb_q[Q_W-1]) begin
						res_status_q <= STAT_MB_ONE;
						state_q      <= ST_EMIT;
					end else if (zero_div_q) begin
						res_status_q <= STAT_ZERO_DIV;
						state_q      <= ST_EMIT;
					end else begin
						state_q <= ST_FST_GO;
					end
				end
				ST_FST_GO: begin
					state_q <= (sum_mi_q > sub_q) ? ST_FST_WAIT : ST_EMIT;
				end
				ST_FST_WAIT: begin
					if (div_rsp.done) begin
						res_fst_q <= (div_rsp.quotient > FST_ONE) ? 32'h8000_0000
						                                          : div_rsp.quotient[31:0];
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// Hand the result over and start a fresh set.
					if (!out_valid_q) begin
						out_valid_q  <= 1'b1;
						out_fst_q    <= res_fst_q;
						out_status_q <= res_status_q;
						for (int i = 0; i < MAX_POPULATIONS; i++) begin
							totals_q[i] <= '0;
						end
						npop_q     <= '0;
						sat_q      <= 1'b0;
						first_v_q  <= 1'b0;
						multi_q    <= 1'b0;
						clr_addr_q <= '0;
						state_q    <= ST_CLEAR;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_fst_q;
	assign m_axis_tuser  = out_status_q;

endmodule
